// ----- rtl/core/cual_pkg.sv -----
// Shared types and constants for the card ID allowlist with enrollment.
// Used by the top level, the slot RAM instance and the port checker.
`default_nettype none

package cual_pkg;

  localparam int TABLE_SLOTS = 128;
  localparam int ID_BYTES    = 10;
  localparam int SLOT_AW     = $clog2(TABLE_SLOTS);
  localparam int LEN_W       = 4;
  localparam int LO_W        = 64;
  localparam int HI_W        = 16;
  localparam int SLOT_W      = LEN_W + HI_W + LO_W;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [2:0] {
    REQ_CARD_PRESENT   = 3'd0,
    REQ_CARD_REMOVED   = 3'd1,
    REQ_ENROLL_START   = 3'd2,
    REQ_ENROLL_EXPIRED = 3'd3,
    REQ_REVOKE         = 3'd4
  } req_type_t;

  typedef enum logic [2:0] {
    ENR_IDLE    = 3'd0,
    ENR_WAIT    = 3'd1,
    ENR_REMOVE  = 3'd2,
    ENR_SUCCESS = 3'd3,
    ENR_FAIL    = 3'd4
  } enroll_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [HI_W-1:0]  hi;
    logic [LO_W-1:0]  lo;
  } slot_t;

  // Result flags that leave the finish step, packed as in out_tdata.
  typedef struct packed {
    logic       revoked;
    logic       table_full;
    logic       save_table;
    logic       auth_state_changed;
    logic [2:0] auth_state;
    logic       open_door;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/cual_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the card ID slots; no dependencies.
`default_nettype none

module cual_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 84,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/card_uid_allowlist_with_enrollment.sv -----
// Top level of the card ID allowlist with its enrollment state machine.
// Depends on cual_pkg and cual_ram.
//
// Each request beat carries a request kind in in_tuser and a card ID in
// in_tdata; every request yields exactly one result beat. Card checks in idle,
// enrollment of a card while waiting, and revokes, when the ID length is not
// zero, walk the slot RAM one slot per cycle through its single read port and
// end early at the first hit; all other requests go straight to the finish
// step. One request is handled at a time, while a finished result may still
// sit in the output register. Slot occupancy is held in per-slot valid flops
// cleared by reset, so no clearing pass is needed.
`default_nettype none

module card_uid_allowlist_with_enrollment
  import cual_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [3:0] uid_length, [67:4] uid_low, [83:68] uid_high, [87:84] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] req_type
  input  wire logic [2:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] open_door, [3:1] auth_state, [4] auth_state_changed, [5] save_table,
  // [6] table_full, [7] revoked
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(TABLE_SLOTS - 1);

  ctrl_state_t              state_r, state_nxt;
  enroll_state_t            enr_r, enr_nxt;
  logic [2:0]               req_r;
  logic [LEN_W-1:0]         len_r;
  logic [LO_W-1:0]          lo_r;
  logic [HI_W-1:0]          hi_r;
  logic                     scan_empty_r;
  logic [SLOT_AW-1:0]       scan_addr_r, scan_addr_nxt;
  logic                     issue_r, issue_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_AW-1:0]       cmp_idx_r;
  logic                     found_r, found_nxt;
  logic [SLOT_AW-1:0]       found_idx_r, found_idx_nxt;
  logic [TABLE_SLOTS-1:0]   valid_r, valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  result_t                  out_data_r, res;

  logic                     in_acc;
  logic [LEN_W-1:0]         in_len, len_sat;
  logic [LO_W-1:0]          lo_m;
  logic [HI_W-1:0]          hi_m;
  logic                     need_scan;
  logic                     out_free;
  logic                     finish_go;
  slot_t                    rd_slot;
  logic [SLOT_W-1:0]        rd_raw;
  logic [LEN_W-1:0]         eff_len;
  logic                     hit;
  logic                     scan_end;
  logic                     ram_we;
  logic                     valid_set, valid_clr;

  assign in_tready  = (state_r == CS_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign finish_go  = (state_r == CS_FINISH) && out_free;

  // Saturate the length and zero every byte at or beyond it.
  assign in_len  = in_tdata[LEN_W-1:0];
  assign len_sat = (in_len > LEN_W'(ID_BYTES)) ? LEN_W'(ID_BYTES) : in_len;

  always_comb begin
    for (int b = 0; b < LO_W / 8; b++) begin
      lo_m[8*b +: 8] = (LEN_W'(b) < len_sat) ? in_tdata[LEN_W + 8*b +: 8] : 8'd0;
    end
    for (int b = 0; b < HI_W / 8; b++) begin
      hi_m[8*b +: 8] = (LEN_W'(b + LO_W / 8) < len_sat) ?
                       in_tdata[LEN_W + LO_W + 8*b +: 8] : 8'd0;
    end
  end

  // Only card checks in idle, enrollment while waiting, and revokes use the table.
  always_comb begin
    need_scan = 1'b0;
    if (len_sat != '0) begin
      if (in_tuser == REQ_CARD_PRESENT) begin
        need_scan = (enr_r == ENR_IDLE) || (enr_r == ENR_WAIT);
      end else if (in_tuser == REQ_REVOKE) begin
        need_scan = 1'b1;
      end
    end
  end

  cual_ram #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH (SLOT_W)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (found_idx_r),
    .wdata ({len_r, hi_r, lo_r}),
    .re    ((state_r == CS_SCAN) && issue_r),
    .raddr (scan_addr_r),
    .rdata (rd_raw)
  );

  assign rd_slot = slot_t'(rd_raw);
  assign eff_len = valid_r[cmp_idx_r] ? rd_slot.len : '0;
  assign hit     = cmp_vld_r &&
                   (scan_empty_r ? (eff_len == '0)
                                 : ((eff_len == len_r) && (rd_slot.lo == lo_r) &&
                                    (rd_slot.hi == hi_r)));
  assign scan_end = hit || (cmp_vld_r && (cmp_idx_r == LAST_SLOT));

  // Control state sequencing.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_acc) begin
          state_nxt = need_scan ? CS_SCAN : CS_FINISH;
        end
      end
      CS_SCAN: begin
        if (scan_end) begin
          state_nxt = CS_FINISH;
        end
      end
      CS_FINISH: begin
        if (out_free) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Scan pipeline: read one slot per cycle, compare it in the next.
  always_comb begin
    scan_addr_nxt = scan_addr_r;
    issue_nxt     = issue_r;
    cmp_vld_nxt   = 1'b0;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    if (in_acc) begin
      scan_addr_nxt = '0;
      issue_nxt     = 1'b1;
      found_nxt     = 1'b0;
    end else if (state_r == CS_SCAN) begin
      if (issue_r) begin
        scan_addr_nxt = scan_addr_r + 1'b1;
        issue_nxt     = (scan_addr_r != LAST_SLOT);
      end
      cmp_vld_nxt = issue_r && !scan_end;
      if (hit) begin
        found_nxt     = 1'b1;
        found_idx_nxt = cmp_idx_r;
      end
    end
  end

  // Result and table update of the finish step.
  always_comb begin
    res       = '0;
    enr_nxt   = enr_r;
    ram_we    = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    case (req_type_t'(req_r))
      REQ_CARD_PRESENT: begin
        if (enr_r == ENR_IDLE) begin
          res.open_door = found_r;
        end else if (enr_r == ENR_WAIT) begin
          enr_nxt                = ENR_REMOVE;
          res.auth_state_changed = 1'b1;
          if (len_r != '0) begin
            res.save_table = found_r;
            res.table_full = !found_r;
            ram_we         = found_r && finish_go;
            valid_set      = found_r;
          end
        end
      end
      REQ_CARD_REMOVED: begin
        if (enr_r == ENR_REMOVE) begin
          enr_nxt                = ENR_SUCCESS;
          res.auth_state_changed = 1'b1;
        end
      end
      REQ_ENROLL_START: begin
        enr_nxt                = ENR_WAIT;
        res.auth_state_changed = 1'b1;
      end
      REQ_ENROLL_EXPIRED: begin
        enr_nxt                = ENR_IDLE;
        res.auth_state_changed = 1'b1;
      end
      REQ_REVOKE: begin
        res.revoked = found_r;
        valid_clr   = found_r;
      end
      default: begin
      end
    endcase
    res.auth_state = enr_nxt;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (finish_go && valid_set) begin
      valid_nxt[found_idx_r] = 1'b1;
    end else if (finish_go && valid_clr) begin
      valid_nxt[found_idx_r] = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      enr_r       <= ENR_IDLE;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish_go) begin
        enr_r <= enr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    cmp_idx_r   <= scan_addr_r;
    found_idx_r <= found_idx_nxt;
    if (in_acc) begin
      req_r        <= in_tuser;
      len_r        <= len_sat;
      lo_r         <= lo_m;
      hi_r         <= hi_m;
      scan_empty_r <= (in_tuser == REQ_CARD_PRESENT) && (enr_r == ENR_WAIT);
    end
    if (finish_go) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cual_chk.sv -----
// Port-level checker for the card ID allowlist, bound to the top level.
// Depends on cual_pkg and card_uid_allowlist_with_enrollment.
`default_nettype none

module cual_chk
  import cual_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while the previous one is in work");

  // A door opening comes only from an idle check with no other flag.
  a_open_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[3:1] == ENR_IDLE && out_tdata[7:4] == 4'd0)
    else $error("open_door with other flags or a non-idle state");

  // Enrollment either writes a slot or reports a full table, never both.
  a_save_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[5] && out_tdata[6]))
    else $error("save_table and table_full both set");

endmodule

bind card_uid_allowlist_with_enrollment cual_chk u_cual_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
